[design/lpks_pkg.sv]
// Shared types and constants for the linear probing key set.
package lpks_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned HASH_W       = 64;
  localparam int unsigned SLOT_W       = 6;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_ABSENT   = 2'd1,
    ST_INSERTED = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic              kind;
    logic [KEY_W-1:0]  key_id;
    logic [HASH_W-1:0] key_hash;
  } in_word_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } out_word_t;

  // one table entry: occupancy flag and key
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } entry_t;

endpackage

[design/lpks_mem.sv]
// Single-port-write, registered-read entry memory for the key set.
module lpks_mem #(
  parameter int unsigned DEPTH = lpks_pkg::CAPACITY_DEF,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_W-1:0]     waddr,
  input  lpks_pkg::entry_t      wdata,
  input  logic [ADDR_W-1:0]     raddr,
  output lpks_pkg::entry_t      rdata
);
  import lpks_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/lpks_ctrl.sv]
// Probe sequencer: clearing pass, slot-by-slot probing, result register.
module lpks_ctrl #(
  parameter int unsigned CAPACITY = lpks_pkg::CAPACITY_DEF,
  localparam int unsigned IDX_W = $clog2(CAPACITY)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lpks_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lpks_pkg::out_word_t  out_data,
  output logic                 mem_we,
  output logic [IDX_W-1:0]     mem_waddr,
  output lpks_pkg::entry_t     mem_wdata,
  output logic [IDX_W-1:0]     mem_raddr,
  input  lpks_pkg::entry_t     mem_rdata
);
  import lpks_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_PROBE = 3'b100
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic             ins_r, ins_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_data_r, out_data_nxt;

  logic             hit, empty, stop, out_free, fire;
  logic [IDX_W-1:0] home;
  status_t          status;

  assign home     = in_data.key_hash[IDX_W-1:0];
  assign hit      = mem_rdata.valid && (mem_rdata.key == key_r);
  assign empty    = !mem_rdata.valid;
  assign stop     = hit || empty || (cnt_r == LAST_IDX);
  assign out_free = !out_valid_r || out_ready;
  assign fire     = (state_r == S_PROBE) && stop && out_free;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    if (hit) begin
      status = ST_FOUND;
    end else if (!ins_r) begin
      status = ST_ABSENT;
    end else if (empty) begin
      status = ST_INSERTED;
    end else begin
      status = ST_FULL;
    end
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    key_nxt   = key_r;
    ins_nxt   = ins_r;
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = '{valid: 1'b1, key: key_r};
    mem_raddr = idx_r;   // re-read the same slot while stalled
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          mem_raddr = home;
          idx_nxt   = home;
          cnt_nxt   = '0;
          key_nxt   = in_data.key_id;
          ins_nxt   = in_data.kind;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!stop) begin
          idx_nxt   = idx_r + 1'b1;   // wraps at capacity
          cnt_nxt   = cnt_r + 1'b1;
          mem_raddr = idx_r + 1'b1;
        end else if (out_free) begin
          mem_we    = (status == ST_INSERTED);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fire) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{status: status, slot: SLOT_W'(idx_r)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    key_r      <= key_nxt;
    ins_r      <= ins_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/linear_probe_key_set_unit.sv]
// Top level of the linear probing key set: sequencer plus entry memory.
//
//   channel | ports                        | word
//   --------+------------------------------+---------------------------
//   input   | in_valid, in_ready, in_data  | kind, key_id, key_hash
//   result  | out_valid, out_ready, out_data | status, slot
//
// An item probes P slots (1 to CAPACITY) through the single read port of
// the entry memory: one slot is examined per cycle.
// After reset a clearing pass writes every entry, with in_ready low.
// A stalled result holds the sequencer on its last probe;
// a new word is accepted as soon as the result sits in the output register.
module linear_probe_key_set_unit #(
  parameter int unsigned CAPACITY = lpks_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lpks_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lpks_pkg::out_word_t out_data
);
  import lpks_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_wdata;
  entry_t           mem_rdata;

  lpks_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  lpks_mem #(.DEPTH(CAPACITY)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // an insert only fills a slot that read back empty
  a_fill_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_wdata.valid) |-> !mem_rdata.valid)
    else $error("insert overwrote an occupied slot");

  // every insert write is reported as inserted in the next cycle
  a_fill_reported: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_wdata.valid) |=> (out_valid && out_data.status == ST_INSERTED))
    else $error("insert write without inserted result");

  // a pending result is never dropped
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("pending result lost");

  // no word is taken while a probe is running
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word accepted during probe");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the linear probing key set unit.
`timescale 1ns / 1ps

module testbench;
  import lpks_pkg::*;

  localparam int CLK_HALF  = 6;
  localparam int IDLE_PCT  = 26;
  localparam int BAD_SHOWN = 10;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  linear_probe_key_set_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #CLK_HALF clk = ~clk;

  // shadow copy of the table
  logic [KEY_W-1:0] shadow_key [CAPACITY_DEF];
  logic             shadow_used[CAPACITY_DEF];
  int               shadow_count = 0;

  in_word_t  word_q[$];
  out_word_t resp_q[$];
  out_word_t want_w;

  logic [KEY_W-1:0]  known_key[$];
  logic [HASH_W-1:0] known_hash[$];

  int  cyc = 0;
  bit  calm;
  int  n_sent = 0;
  int  n_got = 0;
  int  n_bad = 0;
  int  status_seen[4] = '{0, 0, 0, 0};

  // quiet window with no idling on either side
  assign calm = (cyc >= 3000) && (cyc < 7000);

  // Probe from the home slot, update the shadow table, return the response.
  function automatic out_word_t set_response(in_word_t w);
    out_word_t r;
    int        pos;
    bit        done;
    pos      = int'(w.key_hash & (CAPACITY_DEF - 1));
    done     = 1'b0;
    r.status = ST_FULL;
    r.slot   = '0;
    for (int n = 0; n < CAPACITY_DEF && !done; n++) begin
      r.slot = pos[SLOT_W-1:0];
      if (!shadow_used[pos]) begin
        done = 1'b1;
        if (w.kind) begin
          shadow_used[pos] = 1'b1;
          shadow_key[pos]  = w.key_id;
          shadow_count++;
          r.status = ST_INSERTED;
        end else begin
          r.status = ST_ABSENT;
        end
      end else if (shadow_key[pos] == w.key_id) begin
        done     = 1'b1;
        r.status = ST_FOUND;
      end else begin
        pos = (pos + 1) % CAPACITY_DEF;
      end
    end
    // wrapped all the way around: r.slot is the slot just before home
    if (!done) r.status = w.kind ? ST_FULL : ST_ABSENT;
    return r;
  endfunction

  function automatic in_word_t mk_word(logic kind, logic [KEY_W-1:0] key,
                                       logic [HASH_W-1:0] hsh);
    in_word_t w;
    w.kind     = kind;
    w.key_id   = key;
    w.key_hash = hsh;
    return w;
  endfunction

  function automatic logic [HASH_W-1:0] rand_hash(bit clustered);
    logic [HASH_W-1:0] h;
    h = {$urandom, $urandom};
    if (clustered) h[SLOT_W-1:0] = SLOT_W'($urandom_range(7));
    return h;
  endfunction

  task automatic push_insert(logic [KEY_W-1:0] key, logic [HASH_W-1:0] hsh);
    word_q.push_back(mk_word(1'b1, key, hsh));
    known_key.push_back(key);
    known_hash.push_back(hsh);
  endtask

  // Mostly well-formed traffic against keys already offered, some noise.
  task automatic add_mix(input int count, input int new_pct);
    int r;
    int k;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      k = $urandom_range(known_key.size() - 1);
      if (r < new_pct) begin
        push_insert($urandom, rand_hash(1'($urandom_range(1))));
      end else if (r < 35) begin
        word_q.push_back(mk_word(1'b1, known_key[k], known_hash[k]));
      end else if (r < 70) begin
        word_q.push_back(mk_word(1'b0, known_key[k], known_hash[k]));
      end else if (r < 85) begin
        word_q.push_back(mk_word(1'b0, $urandom, rand_hash(1'($urandom_range(1)))));
      end else if (r < 93) begin
        // known key, wrong home
        word_q.push_back(mk_word(1'b0, known_key[k], rand_hash(1'b0)));
      end else begin
        word_q.push_back(mk_word(1'($urandom_range(1)), $urandom, rand_hash(1'b0)));
      end
    end
  endtask

  task automatic wait_drained;
    while (word_q.size() != 0 || in_valid || resp_q.size() != 0) @(posedge clk);
  endtask

  task automatic report_bad(string what, out_word_t want, out_word_t got);
    n_bad++;
    if (n_bad <= BAD_SHOWN)
      $display("[%0t] %s: expected status %0d slot %0d, got status %0d slot %0d",
               $time, what, want.status, want.slot, got.status, got.slot);
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        resp_q.push_back(set_response(in_data));
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (word_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data  <= word_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    if (rst_n && out_valid && out_ready) begin
      n_got++;
      status_seen[out_data.status]++;
      if (resp_q.size() == 0) begin
        report_bad("unexpected word", '0, out_data);
      end else begin
        want_w = resp_q.pop_front();
        if (out_data.status !== want_w.status || out_data.slot !== want_w.slot)
          report_bad("mismatch", want_w, out_data);
      end
    end
  end

  initial begin
    for (int i = 0; i < CAPACITY_DEF; i++) begin
      shadow_used[i] = 1'b0;
      shadow_key[i]  = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed, on an empty table
    word_q.push_back(mk_word(1'b0, 32'd1, 64'd0));
    push_insert(32'd0, 64'd0);                            // key zero is ordinary
    word_q.push_back(mk_word(1'b0, 32'd0, 64'd0));
    word_q.push_back(mk_word(1'b1, 32'd0, 64'd0));        // already present
    push_insert(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);  // last slot
    push_insert(32'h8000_0001, 64'h8000_0000_0000_003F);  // wraps past slot 0
    word_q.push_back(mk_word(1'b0, 32'h8000_0001, 64'h8000_0000_0000_003F));
    word_q.push_back(mk_word(1'b0, 32'd5, 64'h0000_0000_0000_003F));
    word_q.push_back(mk_word(1'b0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
    push_insert(32'hAAAA_5555, 64'h5555_AAAA_5555_AA80);
    word_q.push_back(mk_word(1'b0, 32'h5555_AAAA, 64'hAAAA_5555_AAAA_5540));
    word_q.push_back(mk_word(1'b1, 32'hAAAA_5555, 64'h5555_AAAA_5555_AA80));
    wait_drained();

    // growth: table fills slowly under mixed traffic
    add_mix(600, 10);
    wait_drained();

    // top up until full, then traffic against a full table
    for (int i = 0; i < CAPACITY_DEF + 6; i++) push_insert($urandom, rand_hash(1'b0));
    word_q.push_back(mk_word(1'b0, $urandom, rand_hash(1'b0)));
    word_q.push_back(mk_word(1'b1, $urandom, rand_hash(1'b0)));
    add_mix(330, 15);

    wait_drained();
    repeat (CAPACITY_DEF + 16) @(posedge clk);
    n_bad += resp_q.size();

    $display("Ran %0d words, %0d results; table held %0d of %0d keys at the end",
             n_sent, n_got, shadow_count, CAPACITY_DEF);
    $display("Results: %0d found, %0d absent, %0d inserted, %0d dropped on full table",
             status_seen[ST_FOUND], status_seen[ST_ABSENT],
             status_seen[ST_INSERTED], status_seen[ST_FULL]);
    if (n_bad == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout");
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
design/lpks_pkg.sv
design/lpks_mem.sv
design/lpks_ctrl.sv
design/linear_probe_key_set_unit.sv
tb/sv/testbench.sv
